// ----- rtl/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared sizes, types and helpers of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int ENTRIES   = 16;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 5;
    localparam int AGE_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int CAP_RESET = (ENTRIES < 16) ? ENTRIES : 16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef logic signed [DATA_W-1:0]     t_word;
    typedef logic [ENTRIES-1:0]           t_mask;
    typedef logic [ENTRIES-1:0][DATA_W-1:0] t_word_arr;
    typedef logic [ENTRIES-1:0][AGE_W-1:0]  t_age_arr;
    typedef logic [CNT_W-1:0]             t_count;

    typedef struct packed {
        logic  put;
        t_word key;
        t_word value;
    } t_req;

    typedef struct packed {
        logic  found;
        t_word read_value;
        logic  evicted;
        t_word evicted_key;
    } t_rsp;

    typedef struct packed {
        logic  hit;
        t_mask hit_oh;
        t_mask free_oh;
        t_mask lru_oh;
    } t_match;

    function automatic t_count clamp_capacity(input logic [CFG_W-1:0] v);
        t_count r;
        if (v == '0) begin
            r = t_count'(1);
        end else if (int'(v) > ENTRIES) begin
            r = t_count'(ENTRIES);
        end else begin
            r = t_count'(v);
        end
        return r;
    endfunction

endpackage

// ----- rtl/lkv_match.sv -----
// ----------------------------------------------------------------------------
// lkv_match
// Parallel key compare and slot selection over all entries.
// ----------------------------------------------------------------------------
module lkv_match (
    input  lkv_pkg::t_mask     i_valid,
    input  lkv_pkg::t_word_arr i_keys,
    input  lkv_pkg::t_age_arr  i_ages,
    input  lkv_pkg::t_count    i_count,
    input  lkv_pkg::t_word     i_key,
    output lkv_pkg::t_match    o_match
);

    lkv_pkg::t_mask w_eq;
    lkv_pkg::t_mask w_free;
    lkv_pkg::t_mask w_lru;

    always_comb begin
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            w_eq[i]   = i_valid[i] && (i_keys[i] == i_key);
            w_free[i] = !i_valid[i];
            // The least recent valid entry holds the largest age, live count minus one.
            w_lru[i]  = i_valid[i] &&
                        (lkv_pkg::CNT_W'(i_ages[i]) == i_count - lkv_pkg::CNT_W'(1));
        end
    end

    assign o_match.hit     = |w_eq;
    assign o_match.hit_oh  = w_eq & (~w_eq + lkv_pkg::ENTRIES'(1));
    assign o_match.free_oh = w_free & (~w_free + lkv_pkg::ENTRIES'(1));
    assign o_match.lru_oh  = w_lru;

endmodule

// ----- rtl/lkv_store.sv -----
// ----------------------------------------------------------------------------
// lkv_store
// Entry registers with their update logic and the response of one request.
// ----------------------------------------------------------------------------
module lkv_store (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  lkv_pkg::t_req   i_req,
    input  lkv_pkg::t_count i_cap,
    output lkv_pkg::t_rsp   o_rsp
);

    lkv_pkg::t_mask     r_valid, n_valid;
    lkv_pkg::t_word_arr r_keys, n_keys;
    lkv_pkg::t_word_arr r_values, n_values;
    lkv_pkg::t_age_arr  r_ages, n_ages;
    lkv_pkg::t_count    r_count, n_count;

    lkv_pkg::t_match    w_match;
    logic                   w_full;
    logic                   w_evict;
    lkv_pkg::t_mask         w_slot;
    logic [lkv_pkg::AGE_W-1:0] w_hit_age;
    logic [lkv_pkg::DATA_W-1:0] w_hit_value;
    logic [lkv_pkg::DATA_W-1:0] w_lru_key;

    lkv_match u_match (
        .i_valid (r_valid),
        .i_keys  (r_keys),
        .i_ages  (r_ages),
        .i_count (r_count),
        .i_key   (i_req.key),
        .o_match (w_match)
    );

    assign w_full  = (r_count >= i_cap);
    assign w_evict = i_req.put && !w_match.hit && w_full;
    assign w_slot  = w_full ? w_match.lru_oh : w_match.free_oh;

    always_comb begin
        w_hit_age   = '0;
        w_hit_value = '0;
        w_lru_key   = '0;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            if (w_match.hit_oh[i]) begin
                w_hit_age   = w_hit_age | r_ages[i];
                w_hit_value = w_hit_value | r_values[i];
            end
            if (w_match.lru_oh[i]) begin
                w_lru_key = w_lru_key | r_keys[i];
            end
        end
    end

    always_comb begin
        o_rsp.found       = w_match.hit;
        o_rsp.evicted     = w_evict;
        o_rsp.evicted_key = w_evict ? lkv_pkg::t_word'(w_lru_key) : '0;
        if (i_req.put == lkv_pkg::CMD_PUT) begin
            o_rsp.read_value = '0;
        end else if (w_match.hit) begin
            o_rsp.read_value = lkv_pkg::t_word'(w_hit_value);
        end else begin
            o_rsp.read_value = '1;
        end
    end

    always_comb begin
        n_valid  = r_valid;
        n_keys   = r_keys;
        n_values = r_values;
        n_ages   = r_ages;
        n_count  = r_count;
        if (w_match.hit) begin
            for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                if (w_match.hit_oh[i]) begin
                    n_ages[i] = '0;
                    if (i_req.put == lkv_pkg::CMD_PUT) begin
                        n_values[i] = i_req.value;
                    end
                end else if (r_valid[i] && (r_ages[i] < w_hit_age)) begin
                    n_ages[i] = r_ages[i] + lkv_pkg::AGE_W'(1);
                end
            end
        end else if (i_req.put == lkv_pkg::CMD_PUT) begin
            for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                if (w_slot[i]) begin
                    n_valid[i]  = 1'b1;
                    n_keys[i]   = i_req.key;
                    n_values[i] = i_req.value;
                    n_ages[i]   = '0;
                end else if (r_valid[i]) begin
                    n_ages[i] = r_ages[i] + lkv_pkg::AGE_W'(1);
                end
            end
            if (!w_full) begin
                n_count = r_count + lkv_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ages  <= '0;
            r_count <= '0;
        end else if (i_go) begin
            r_valid <= n_valid;
            r_ages  <= n_ages;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_keys   <= n_keys;
            r_values <= n_values;
        end
    end

endmodule

// ----- rtl/lru_key_value_cache_top.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least-recently-used replacement.
//
// Channel   Handshake                      Payload
// in        i_in_valid / o_in_ready        i_command, i_key, i_value
// out       o_out_valid / i_out_ready      o_found, o_read_value, o_evicted,
//                                          o_evicted_key
// cfg       i_cfg_we                       i_cfg_data (capacity)
//
// One word is accepted every cycle while the response side is not stalled;
// each request word passes through the input register and then the response
// register. All entries are compared and aged in parallel in the combinational
// logic between the input register and the response register.
// Reset empties the cache at once and sets capacity to 16.
// A stalled response holds the request in the input register, after which
// the input side stops accepting.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_command,
    input  logic signed [31:0]           i_key,
    input  logic signed [31:0]           i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_found,
    output logic signed [31:0]           o_read_value,
    output logic                         o_evicted,
    output logic signed [31:0]           o_evicted_key,
    input  logic                         i_cfg_we,
    input  logic [lkv_pkg::CFG_W-1:0]    i_cfg_data
);

    logic            r_in_valid;
    lkv_pkg::t_req   r_in_req;
    logic            r_out_valid;
    lkv_pkg::t_rsp   r_out_rsp;
    lkv_pkg::t_count r_capacity;
    lkv_pkg::t_rsp   w_rsp;
    logic            w_go;

    assign w_go       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_capacity  <= lkv_pkg::t_count'(lkv_pkg::CAP_RESET);
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_capacity <= lkv_pkg::clamp_capacity(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_req.put   <= i_command;
            r_in_req.key   <= i_key;
            r_in_req.value <= i_value;
        end
        if (w_go) begin
            r_out_rsp <= w_rsp;
        end
    end

    lkv_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_req   (r_in_req),
        .i_cap   (r_capacity),
        .o_rsp   (w_rsp)
    );

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_rsp.found;
    assign o_read_value  = r_out_rsp.read_value;
    assign o_evicted     = r_out_rsp.evicted;
    assign o_evicted_key = r_out_rsp.evicted_key;

endmodule

// ----- rtl/lkv_checker.sv -----
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks of the LRU key/value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkv_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic                      o_found,
    input logic signed [31:0]        o_read_value,
    input logic                      o_evicted,
    input logic signed [31:0]        o_evicted_key
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_value))
        else $error("Response word changed while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Response valid right after reset.");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted |-> !o_found && (o_read_value == 0))
        else $error("Eviction reported on a hit or with read data.");

    a_no_evict_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted |-> (o_evicted_key == 0))
        else $error("Evicted key is nonzero without an eviction.");

endmodule

bind lru_key_value_cache_top lkv_checker u_lkv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_found       (o_found),
    .o_read_value  (o_read_value),
    .o_evicted     (o_evicted),
    .o_evicted_key (o_evicted_key)
);
